// ----- rtl/lsbas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lsbas_pkg;

  localparam logic [3:0] MAX_BYTES  = 4'd8;
  localparam logic [3:0] BUS_BYTES  = 4'd4;
  localparam int         MAX_PIECES = 4;

  typedef enum logic [3:0] {
    CMD_LOAD     = 4'd0,
    CMD_ST_BYTE  = 4'd1,
    CMD_ST_HALF  = 4'd2,
    CMD_ST_WORD  = 4'd3,
    CMD_ST_DBL   = 4'd4,
    CMD_ST_LOW   = 4'd5,
    CMD_ST_HREV  = 4'd6,
    CMD_ST_WREV  = 4'd7,
    CMD_ST_MSB   = 4'd8
  } lsbas_cmd_t;

  typedef enum logic [2:0] {
    OP_RD_BYTE = 3'd0,
    OP_RD_HALF = 3'd1,
    OP_RD_WORD = 3'd2,
    OP_WR_BYTE = 3'd3,
    OP_WR_HALF = 3'd4,
    OP_WR_WORD = 3'd5
  } lsbas_op_t;

  typedef enum logic [1:0] {
    PSZ_BYTE = 2'd0,
    PSZ_HALF = 2'd1,
    PSZ_WORD = 2'd2
  } lsbas_psz_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  size;
    logic [63:0] mem;
    logic        store;
    logic [4:0]  tag;
  } lsbas_item_t;

endpackage

`default_nettype wire

// ----- rtl/load_store_bus_access_splitter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Splits one load or store request into naturally aligned byte, halfword
// and word accesses for a 32-bit bus. Store data is laid out in memory
// byte order first (big-endian, byte-reversed or string form), then each
// piece carries its address, operation, right-aligned write data, offset
// within the request and a last mark. A request of 1 to 8 bytes yields 1
// to 4 pieces (none for a zero size); the splitter stage emits one piece
// per cycle while out_ready does not stall it, taking the next request as
// its last piece fires, while the layout and input stages fill behind it.
// A request passes input, layout, splitter and output registers in turn.
module load_store_bus_access_splitter_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [3:0]  in_command,
  input  wire  [31:0] in_address,
  input  wire  [3:0]  in_access_size,
  input  wire  [63:0] in_register_value,
  input  wire  [4:0]  in_register_number,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_bus_address,
  output logic [2:0]  out_bus_operation,
  output logic [31:0] out_write_data,
  output logic [2:0]  out_byte_offset,
  output logic [4:0]  out_tag_register,
  output logic        out_last_piece
);
  import lsbas_pkg::*;

  // input stage
  logic        s1_v_r;
  logic [3:0]  s1_cmd_r;
  logic [31:0] s1_addr_r;
  logic [3:0]  s1_size_r;
  logic [63:0] s1_val_r;
  logic [4:0]  s1_tag_r;

  // layout stage
  logic        s2_v_r;
  lsbas_item_t s2_item_r;
  lsbas_item_t s2_item_nxt;

  logic s2_ready;
  logic sp_ready;

  assign s2_ready = !s2_v_r || sp_ready;
  assign in_ready = !s1_v_r || s2_ready;

  always_comb begin
    s2_item_nxt.addr  = s1_addr_r;
    s2_item_nxt.size  = (s1_size_r > MAX_BYTES) ? MAX_BYTES : s1_size_r;
    s2_item_nxt.tag   = s1_tag_r;
    s2_item_nxt.store = 1'b1;
    case (s1_cmd_r)
      CMD_ST_BYTE: s2_item_nxt.mem = {s1_val_r[7:0], 56'd0};
      CMD_ST_HALF: s2_item_nxt.mem = {s1_val_r[15:0], 48'd0};
      CMD_ST_WORD: s2_item_nxt.mem = {s1_val_r[31:0], 32'd0};
      CMD_ST_DBL:  s2_item_nxt.mem = s1_val_r;
      CMD_ST_LOW:  s2_item_nxt.mem = {s1_val_r[31:0], 32'd0};
      CMD_ST_HREV: s2_item_nxt.mem = {s1_val_r[7:0], s1_val_r[15:8], 48'd0};
      CMD_ST_WREV: s2_item_nxt.mem = {s1_val_r[7:0], s1_val_r[15:8],
                                      s1_val_r[23:16], s1_val_r[31:24], 32'd0};
      CMD_ST_MSB:  s2_item_nxt.mem = {s1_val_r[31:0], 32'd0};
      default: begin
        s2_item_nxt.mem   = 64'd0;
        s2_item_nxt.store = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_address;
      s1_size_r <= in_access_size;
      s1_val_r  <= in_register_value;
      s1_tag_r  <= in_register_number;
    end
    if (s1_v_r && s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  lsbas_split u_split (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (s2_v_r),
    .in_ready          (sp_ready),
    .in_item           (s2_item_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bus_address   (out_bus_address),
    .out_bus_operation (out_bus_operation),
    .out_write_data    (out_write_data),
    .out_byte_offset   (out_byte_offset),
    .out_tag_register  (out_tag_register),
    .out_last_piece    (out_last_piece)
  );

  a_half_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bus_operation == OP_RD_HALF || out_bus_operation == OP_WR_HALF)
      |-> !out_bus_address[0])
    else $error("halfword piece on odd address");

  a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bus_operation == OP_RD_WORD || out_bus_operation == OP_WR_WORD)
      |-> out_bus_address[1:0] == 2'd0 && out_byte_offset <= 3'd4)
    else $error("word piece misaligned or past request end");

  a_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bus_operation == OP_RD_BYTE || out_bus_operation == OP_RD_HALF ||
                  out_bus_operation == OP_RD_WORD)
      |-> out_write_data == 32'd0)
    else $error("read piece carries write data");

endmodule

`default_nettype wire

// ----- rtl/lsbas_split.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsbas_split (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lsbas_pkg::lsbas_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [31:0]          out_bus_address,
  output logic [2:0]           out_bus_operation,
  output logic [31:0]          out_write_data,
  output logic [2:0]           out_byte_offset,
  output logic [4:0]           out_tag_register,
  output logic                 out_last_piece
);
  import lsbas_pkg::*;

  // piece plan for the incoming request
  logic [MAX_PIECES-1:0] pv_nxt;
  lsbas_psz_t            psz_nxt  [MAX_PIECES];
  logic [2:0]            off_nxt  [MAX_PIECES];
  logic [MAX_PIECES-1:0] last_nxt;
  logic [3:0]            rem;
  logic [3:0]            cur;
  logic [1:0]            aa;
  logic [3:0]            avail;
  logic [3:0]            ps;

  always_comb begin
    rem = in_item.size;
    cur = 4'd0;
    for (int k = 0; k < MAX_PIECES; k++) begin
      aa    = in_item.addr[1:0] + cur[1:0];
      avail = (rem >= BUS_BYTES) ? BUS_BYTES : rem;
      pv_nxt[k]   = (rem != 4'd0);
      off_nxt[k]  = cur[2:0];
      if (avail == BUS_BYTES && aa == 2'd0) begin
        psz_nxt[k] = PSZ_WORD;
        ps         = 4'd4;
      end else if (avail >= 4'd2 && !aa[0]) begin
        psz_nxt[k] = PSZ_HALF;
        ps         = 4'd2;
      end else begin
        psz_nxt[k] = PSZ_BYTE;
        ps         = 4'd1;
      end
      if (rem == 4'd0) begin
        ps = 4'd0;
      end
      rem = rem - ps;
      cur = cur + ps;
      last_nxt[k] = (rem == 4'd0);
    end
  end

  // splitter stage
  logic                  s3_v_r;
  lsbas_item_t           s3_item_r;
  logic [MAX_PIECES-1:0] pv_r;
  lsbas_psz_t            psz_r  [MAX_PIECES];
  logic [2:0]            off_r  [MAX_PIECES];
  logic [MAX_PIECES-1:0] last_r;
  logic [1:0]            idx_r;

  logic out_free;
  logic fire;
  logic done;
  logic take;
  logic [1:0] idx_inc;

  assign idx_inc  = idx_r + 2'd1;
  assign out_free = !out_valid || out_ready;
  assign fire     = s3_v_r && pv_r[idx_r] && out_free;
  assign done     = s3_v_r && (!pv_r[idx_r] ||
                    (out_free && (idx_r == 2'(MAX_PIECES - 1) || !pv_r[idx_inc])));
  assign in_ready = !s3_v_r || done;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r    <= 1'b0;
      idx_r     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s3_v_r <= 1'b1;
        idx_r  <= 2'd0;
      end else begin
        if (done) begin
          s3_v_r <= 1'b0;
        end
        if (fire) begin
          idx_r <= idx_inc;
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s3_item_r <= in_item;
      pv_r      <= pv_nxt;
      last_r    <= last_nxt;
      for (int k = 0; k < MAX_PIECES; k++) begin
        psz_r[k] <= psz_nxt[k];
        off_r[k] <= off_nxt[k];
      end
    end
  end

  // output register
  logic [5:0]  rot_sh;
  logic [63:0] rot;
  logic [31:0] win;
  logic [31:0] data_nxt;
  lsbas_op_t   op_nxt;

  assign rot_sh = {off_r[idx_r], 3'b000};
  assign rot    = (s3_item_r.mem << rot_sh) | (s3_item_r.mem >> (7'd64 - {1'b0, rot_sh}));
  assign win    = rot[63:32];

  always_comb begin
    case (psz_r[idx_r])
      PSZ_WORD: begin
        data_nxt = win;
        op_nxt   = s3_item_r.store ? OP_WR_WORD : OP_RD_WORD;
      end
      PSZ_HALF: begin
        data_nxt = {16'd0, win[31:16]};
        op_nxt   = s3_item_r.store ? OP_WR_HALF : OP_RD_HALF;
      end
      default: begin
        data_nxt = {24'd0, win[31:24]};
        op_nxt   = s3_item_r.store ? OP_WR_BYTE : OP_RD_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_bus_address   <= s3_item_r.addr + {29'd0, off_r[idx_r]};
      out_bus_operation <= op_nxt;
      out_write_data    <= data_nxt;
      out_byte_offset   <= off_r[idx_r];
      out_tag_register  <= s3_item_r.tag;
      out_last_piece    <= last_r[idx_r];
    end
  end

endmodule

`default_nettype wire
